// File: sv/replicated_log_table_defines.svh
// assertion macros for the replicated log table
// expects clk and rst_n in the scope where a macro is used
`ifndef REPLICATED_LOG_TABLE_DEFINES_SVH
`define REPLICATED_LOG_TABLE_DEFINES_SVH

// same-cycle implication
`define RLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rlt_pkg.sv
// shared types and constants of the replicated log table
// no dependencies
package rlt_pkg;

  localparam int LOG_DEPTH = 64;
  localparam int PEERS     = 5;
  localparam int SLOT_W    = $clog2(LOG_DEPTH);
  localparam int PEER_W    = $clog2(PEERS);
  localparam int STEP_W    = SLOT_W + 1;
  localparam int ENTRY_W   = 96;
  localparam logic [4:0] QUORUM_RESET = 5'd3;
  localparam logic [31:0] IDX_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_UPDATE    = 3'd1,
    CMD_LEAD_CMT  = 3'd2,
    CMD_FOLL_CMT  = 3'd3,
    CMD_ROLLBACK  = 3'd4,
    CMD_CHECK     = 3'd5,
    CMD_VOTE      = 3'd6,
    CMD_RST_PROG  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OUTDATED  = 3'd2,
    ST_COMMITTED = 3'd3,
    ST_GAP       = 3'd4,
    ST_BEYOND    = 3'd5,
    ST_RECOMMIT  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UPD_CMP,
    S_CHK_CMP,
    S_VOTE_CMP,
    S_LC_I,
    S_LC_J,
    S_LC_END,
    S_RB_HI,
    S_RB_CHECK,
    S_RB_CMP,
    S_FIN
  } state_t;

endpackage

// File: sv/replicated_log_table.sv
// replicated log table top level: command sequencer, peer progress, entry ring
// depends on rlt_pkg, rlt_ram and replicated_log_table_defines.svh
//
//  channel | dir | handshake           | contents
//  in_     | in  | in_tvalid/in_tready  | tuser cmd, tdata peer,log_index,term,key,value
//  out_    | out | out_tvalid/out_tready| tdata status,answer,commit,last,peer_progress
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data quorum_count
//
// one word in flight at a time; in_tready is high only when the sequencer is idle
// append, follower commit and progress reset finish in S_EXEC; check, vote and
// an overwriting update add a compare state; leader commit reads one progress per cycle
// rollback walks entries in S_RB_CHECK/S_RB_CMP, at most LOG_DEPTH (one ram read port)
// output register lets the next word be accepted while a result waits
// synchronous active-low reset; term valid bits clear at once, no sweep
module replicated_log_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // cmd
  input  logic [135:0] in_tdata,   // peer, log_index, term, key, value, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // status, answer, commit_index, last_index,
                                   // peer_progress, zero pad
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data // quorum_count
);
  import rlt_pkg::*;

  `include "replicated_log_table_defines.svh"

  // sequencer state
  state_t state_r, state_nxt;

  // latched command word
  cmd_t        cmd_r;
  logic [3:0]  peer_r;
  logic [31:0] idx_r, term_r, key_r, val_r;

  // log bookkeeping
  logic [31:0] last_r, last_nxt;
  logic [31:0] commit_r, commit_nxt;
  logic [31:0] applied_r, applied_nxt;
  logic [4:0]  quorum_r;

  // peer progress
  logic [31:0] prog_r [PEERS];
  logic [PEER_W-1:0] prog_ra;
  logic [31:0] prog_rd;
  logic        prog_we, prog_all;
  logic [31:0] prog_wd;

  // loop registers
  logic [31:0] v_r, v_nxt;
  logic [31:0] thi_r, thi_nxt;
  logic [31:0] pi_r, pi_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [PEER_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [4:0]  cnt_r, cnt_nxt, cnt_sum, need;

  // result
  status_t status_r, status_nxt;
  logic    answer_r, answer_nxt;

  // entry ring
  logic               tvld_r [LOG_DEPTH];
  logic               rd_vld_r;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_wa, ram_ra;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [31:0]        rterm;

  logic        peer_ok, log_full, load_out;
  logic [31:0] v_dec;

  rlt_ram #(.WIDTH(ENTRY_W), .DEPTH(LOG_DEPTH)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata ({val_r, key_r, term_r}),
    .raddr (ram_ra),
    .rdata (ram_rdata)
  );

  // never-written slots read as term zero
  assign rterm    = rd_vld_r ? ram_rdata[31:0] : 32'd0;
  assign peer_ok  = {1'b0, peer_r} < 5'(PEERS);
  assign prog_rd  = prog_r[prog_ra];
  assign log_full = (last_r == IDX_MAX) || ((last_r - applied_r) >= 32'(LOG_DEPTH));
  assign need     = (quorum_r == 5'd0) ? 5'd0 : quorum_r - 5'd1;
  assign in_tready = (state_r == S_IDLE);
  assign v_dec    = v_r - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      last_r    <= '0;
      commit_r  <= '0;
      applied_r <= '0;
      quorum_r  <= QUORUM_RESET;
      out_tvalid <= 1'b0;
      for (int k = 0; k < PEERS; k++) prog_r[k] <= '0;
      for (int k = 0; k < LOG_DEPTH; k++) tvld_r[k] <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      commit_r  <= commit_nxt;
      applied_r <= applied_nxt;
      if (cfg_wr_en) begin
        quorum_r <= cfg_wr_data;
      end
      if (prog_all) begin
        for (int k = 0; k < PEERS; k++) prog_r[k] <= commit_r;
      end else if (prog_we) begin
        prog_r[peer_r[PEER_W-1:0]] <= prog_wd;
      end
      if (ram_we) begin
        tvld_r[ram_wa] <= 1'b1;
      end
      if (load_out) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // payload and loop registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= cmd_t'(in_tuser);
      peer_r <= in_tdata[3:0];
      idx_r  <= in_tdata[35:4];
      term_r <= in_tdata[67:36];
      key_r  <= in_tdata[99:68];
      val_r  <= in_tdata[131:100];
    end
    rd_vld_r <= tvld_r[ram_ra];
    v_r      <= v_nxt;
    thi_r    <= thi_nxt;
    pi_r     <= pi_nxt;
    steps_r  <= steps_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    answer_r <= answer_nxt;
    if (load_out) begin
      out_tdata <= {4'd0, (peer_ok ? prog_rd : 32'd0), last_r, commit_r, answer_r,
                    status_r};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    commit_nxt  = commit_r;
    applied_nxt = applied_r;
    v_nxt       = v_r;
    thi_nxt     = thi_r;
    pi_nxt      = pi_r;
    steps_nxt   = steps_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    answer_nxt  = answer_r;
    prog_we     = 1'b0;
    prog_all    = 1'b0;
    prog_wd     = v_r;
    ram_we      = 1'b0;
    ram_wa      = idx_r[SLOT_W-1:0];
    ram_ra      = idx_r[SLOT_W-1:0];
    load_out    = 1'b0;
    cnt_sum     = cnt_r + ((prog_rd >= pi_r) ? 5'd1 : 5'd0);

    unique case (state_r)
      S_LC_I:  prog_ra = i_r;
      S_LC_J:  prog_ra = j_r;
      default: prog_ra = peer_r[PEER_W-1:0];
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          status_nxt = ST_OK;
          answer_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (cmd_r)
          CMD_APPEND: begin
            if (log_full) begin
              status_nxt = ST_FULL;
            end else begin
              last_nxt = last_r + 32'd1;
              ram_we   = 1'b1;
              ram_wa   = last_nxt[SLOT_W-1:0];
            end
          end
          CMD_UPDATE: begin
            priority if (last_r != IDX_MAX && idx_r == last_r + 32'd1) begin
              if (log_full) begin
                status_nxt = ST_FULL;
              end else begin
                last_nxt = idx_r;
                ram_we   = 1'b1;
              end
            end else if (commit_r < idx_r && idx_r <= last_r) begin
              state_nxt = S_UPD_CMP;
            end else if (idx_r <= commit_r) begin
              status_nxt = ST_COMMITTED;
            end else begin
              status_nxt = ST_GAP;
            end
          end
          CMD_LEAD_CMT: begin
            if (peer_ok) begin
              i_nxt = '0;
              priority if (idx_r > prog_rd) begin
                if (idx_r > last_r) begin
                  status_nxt = ST_BEYOND;
                end else begin
                  prog_we   = 1'b1;
                  prog_wd   = idx_r;
                  state_nxt = S_LC_I;
                end
              end else if (idx_r < prog_rd) begin
                status_nxt = ST_RECOMMIT;
              end else begin
                state_nxt = S_LC_I;
              end
            end
          end
          CMD_FOLL_CMT: begin
            commit_nxt  = (idx_r > last_r) ? last_r : idx_r;
            applied_nxt = commit_nxt;
          end
          CMD_ROLLBACK: begin
            if (peer_ok) begin
              v_nxt     = (prog_rd != 32'd0) ? prog_rd - 32'd1 : 32'd0;
              steps_nxt = '0;
              ram_ra    = v_nxt[SLOT_W-1:0] + SLOT_W'(1);
              state_nxt = S_RB_HI;
            end
          end
          CMD_CHECK: begin
            state_nxt = S_CHK_CMP;
          end
          CMD_VOTE: begin
            ram_ra    = last_r[SLOT_W-1:0];
            state_nxt = S_VOTE_CMP;
          end
          CMD_RST_PROG: begin
            prog_all = 1'b1;
          end
          default: ;
        endcase
      end
      S_UPD_CMP: begin
        state_nxt = S_FIN;
        if (rterm < term_r) begin
          last_nxt = idx_r;
          ram_we   = 1'b1;
        end else if (rterm > term_r) begin
          status_nxt = ST_OUTDATED;
        end
      end
      S_CHK_CMP: begin
        answer_nxt = (idx_r <= last_r) && (rterm == term_r);
        state_nxt  = S_FIN;
      end
      S_VOTE_CMP: begin
        answer_nxt = (term_r > rterm) || ((term_r == rterm) && (idx_r >= last_r));
        state_nxt  = S_FIN;
      end
      S_LC_I: begin
        pi_nxt = prog_rd;
        if (prog_rd <= commit_r) begin
          if (i_r == PEER_W'(PEERS - 1)) begin
            state_nxt = S_LC_END;
          end else begin
            i_nxt = i_r + PEER_W'(1);
          end
        end else begin
          cnt_nxt   = '0;
          j_nxt     = '0;
          state_nxt = S_LC_J;
        end
      end
      S_LC_J: begin
        cnt_nxt = cnt_sum;
        if (j_r == PEER_W'(PEERS - 1)) begin
          if (cnt_sum >= need) begin
            commit_nxt = pi_r;
          end
          if (i_r == PEER_W'(PEERS - 1)) begin
            state_nxt = S_LC_END;
          end else begin
            i_nxt     = i_r + PEER_W'(1);
            state_nxt = S_LC_I;
          end
        end else begin
          j_nxt = j_r + PEER_W'(1);
        end
      end
      S_LC_END: begin
        applied_nxt = commit_r;
        state_nxt   = S_FIN;
      end
      S_RB_HI: begin
        thi_nxt   = rterm;
        state_nxt = S_RB_CHECK;
      end
      S_RB_CHECK: begin
        ram_ra = v_r[SLOT_W-1:0];
        if (steps_r < STEP_W'(LOG_DEPTH) && v_r > applied_r) begin
          state_nxt = S_RB_CMP;
        end else begin
          prog_we   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_RB_CMP: begin
        if (rterm == thi_r) begin
          v_nxt     = v_dec;
          steps_nxt = steps_r + STEP_W'(1);
          thi_nxt   = rterm;
          state_nxt = S_RB_CHECK;
        end else begin
          prog_we   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `RLT_ASSERT_NOW(a_applied_tracks_commit, state_r == S_IDLE, applied_r == commit_r, "applied differs")
  `RLT_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")
  `RLT_ASSERT_NOW(a_out_from_fin, $rose(out_tvalid), $past(state_r) == S_FIN, "result not from finish")
  `RLT_ASSERT_NOW(a_steps_bound, state_r == S_RB_CHECK || state_r == S_RB_CMP, steps_r <= STEP_W'(LOG_DEPTH), "walk overran")

endmodule

// File: sv/rlt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
